FILE: rtl/calendar_date_add_days_macros.svh
// Assertion macros for the checker file of the date shifter.
`ifndef CALENDAR_DATE_ADD_DAYS_MACROS_SVH
`define CALENDAR_DATE_ADD_DAYS_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define CDAD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CDAD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/cdad_pkg.sv
// Types, constants, calendar tables and the microcode program of the date shifter.
package cdad_pkg;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [6:0]  YL_LAST = 7'd99;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        C_NEVER,
        C_BAD_YM,
        C_BAD_DAY,
        C_M_IS_1,
        C_R_NEG,
        C_BACK_STOP,
        C_R_NONNEG,
        C_FWD_STOP,
        C_R_LT_DIY,
        C_R_LT_DIM
    } t_cond;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SPLIT,
        OP_MDEC,
        OP_YDEC_ADD,
        OP_SUBY_YINC,
        OP_MINC,
        OP_FIN_OK,
        OP_FIN_RANGE,
        OP_FIN_INV
    } t_uop;

    // When cond holds the step jumps to target and skips its op; otherwise the op
    // runs and the sequencer moves to next, unless a finishing op waits for output.
    typedef struct packed {
        t_cond cond;
        t_upc  target;
        t_uop  op;
        t_upc  next;
    } t_uword;

    typedef struct packed {
        logic [4:0] dim_cur;
        logic [4:0] dim_prev;
        logic [8:0] diy_cur;
        logic [8:0] diy_prev;
    } t_cal;

    localparam t_upc PC_SPLIT  = 4'd0;
    localparam t_upc PC_DAYCHK = 4'd1;
    localparam t_upc PC_MBACK  = 4'd2;
    localparam t_upc PC_DIR    = 4'd3;
    localparam t_upc PC_YBACK  = 4'd4;
    localparam t_upc PC_BCHK   = 4'd5;
    localparam t_upc PC_YFWD   = 4'd6;
    localparam t_upc PC_FCHK   = 4'd7;
    localparam t_upc PC_MWALK  = 4'd8;
    localparam t_upc PC_RANGE  = 4'd9;
    localparam t_upc PC_OK     = 4'd10;
    localparam t_upc PC_INV    = 4'd11;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            MONTH_FEB:                  len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            PC_SPLIT:  w = '{cond: C_BAD_YM,    target: PC_INV,    op: OP_SPLIT,
                             next: PC_DAYCHK};
            PC_DAYCHK: w = '{cond: C_BAD_DAY,   target: PC_INV,    op: OP_NOP,
                             next: PC_MBACK};
            PC_MBACK:  w = '{cond: C_M_IS_1,    target: PC_DIR,    op: OP_MDEC,
                             next: PC_MBACK};
            PC_DIR:    w = '{cond: C_R_NEG,     target: PC_YBACK,  op: OP_NOP,
                             next: PC_YFWD};
            PC_YBACK:  w = '{cond: C_BACK_STOP, target: PC_BCHK,   op: OP_YDEC_ADD,
                             next: PC_YBACK};
            PC_BCHK:   w = '{cond: C_R_NONNEG,  target: PC_MWALK,  op: OP_NOP,
                             next: PC_RANGE};
            PC_YFWD:   w = '{cond: C_FWD_STOP,  target: PC_FCHK,   op: OP_SUBY_YINC,
                             next: PC_YFWD};
            PC_FCHK:   w = '{cond: C_R_LT_DIY,  target: PC_MWALK,  op: OP_NOP,
                             next: PC_RANGE};
            PC_MWALK:  w = '{cond: C_R_LT_DIM,  target: PC_OK,     op: OP_MINC,
                             next: PC_MWALK};
            PC_RANGE:  w = '{cond: C_NEVER,     target: PC_SPLIT,  op: OP_FIN_RANGE,
                             next: PC_SPLIT};
            PC_OK:     w = '{cond: C_NEVER,     target: PC_SPLIT,  op: OP_FIN_OK,
                             next: PC_SPLIT};
            PC_INV:    w = '{cond: C_NEVER,     target: PC_SPLIT,  op: OP_FIN_INV,
                             next: PC_SPLIT};
            default:   w = '{cond: C_NEVER,     target: PC_INV,    op: OP_NOP,
                             next: PC_INV};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/cdad_cal.sv
// Month and year lengths for the current year and month and for their predecessors.
module cdad_cal (
    input  logic [6:0]    i_yc,
    input  logic [6:0]    i_yl,
    input  logic [3:0]    i_month,
    output cdad_pkg::t_cal o_cal
);

    logic       w_leap_cur;
    logic       w_leap_prev;
    logic [6:0] w_yl_prev;
    logic [3:0] w_month_prev;
    logic [4:0] w_len_cur;
    logic [4:0] w_len_prev;

    // A century year is leap only when the century count is a multiple of four.
    assign w_leap_cur  = (i_yl != 7'd0) ? (i_yl[1:0] == 2'b00) : (i_yc[1:0] == 2'b00);
    assign w_yl_prev   = i_yl - 7'd1;
    // The year before a century year ends in 99 and is never leap.
    assign w_leap_prev = (i_yl != 7'd0) &&
                         ((w_yl_prev != 7'd0) ? (w_yl_prev[1:0] == 2'b00)
                                              : (i_yc[1:0] == 2'b00));

    assign w_month_prev = i_month - 4'd1;
    assign w_len_cur    = cdad_pkg::month_len(i_month);
    assign w_len_prev   = cdad_pkg::month_len(w_month_prev);

    always_comb begin
        o_cal.dim_cur  = w_len_cur + {4'd0, (i_month == cdad_pkg::MONTH_FEB) && w_leap_cur};
        o_cal.dim_prev = w_len_prev +
                         {4'd0, (w_month_prev == cdad_pkg::MONTH_FEB) && w_leap_cur};
        o_cal.diy_cur  = 9'd365 + {8'd0, w_leap_cur};
        o_cal.diy_prev = 9'd365 + {8'd0, w_leap_prev};
    end

endmodule

FILE: rtl/calendar_date_add_days.sv
// Top level of the Gregorian date shifter: microcoded sequencer and datapath.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: year, month, day, day offset
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: year, month, day; tuser: status
//
// The time a request takes grows with its start month, the years crossed and the
// months walked in the final year; the year loop of the microcode, one year per step,
// sets its upper bound.
// Reset is synchronous and clears the step counter, the busy flag and the output valid.
// A new request is taken whenever no request is in progress; the last step waits until
// the output register is free.
module calendar_date_add_days #(
    parameter int OFFSET_BITS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], day_offset, zero fill
    input  logic [((23+OFFSET_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], zero fill
    output logic [23:0]                        m_axis_tdata,
    // status[1:0]
    output logic [1:0]                         m_axis_tuser
);

    localparam int RW = ((OFFSET_BITS > 10) ? OFFSET_BITS : 10) + 1;

    cdad_pkg::t_uword w_uw;
    cdad_pkg::t_cal   w_cal;
    logic             w_cond;
    logic             w_slot_free;
    logic             w_neg;

    logic [OFFSET_BITS-1:0] w_off;
    logic [26:0]            w_prod;
    logic [7:0]             w_q;
    logic [13:0]            w_hund;
    logic [13:0]            w_rem;
    logic signed [RW-1:0]   w_dim_cur;
    logic signed [RW-1:0]   w_dim_prev;
    logic signed [RW-1:0]   w_diy_cur;
    logic signed [RW-1:0]   w_diy_prev;

    cdad_pkg::t_upc       r_pc,  n_pc;
    logic                 r_busy, n_busy;
    logic                 r_out_valid, n_out_valid;
    logic [13:0]          r_in_y, n_in_y;
    logic [3:0]           r_in_m, n_in_m;
    logic [4:0]           r_in_d, n_in_d;
    logic [13:0]          r_y, n_y;
    logic [6:0]           r_yc, n_yc;
    logic [6:0]           r_yl, n_yl;
    logic [3:0]           r_m, n_m;
    logic signed [RW-1:0] r_r, n_r;
    logic [13:0]          r_res_y, n_res_y;
    logic [3:0]           r_res_m, n_res_m;
    logic [4:0]           r_res_d, n_res_d;
    logic [1:0]           r_res_st, n_res_st;

    cdad_cal u_cal (
        .i_yc    (r_yc),
        .i_yl    (r_yl),
        .i_month (r_m),
        .o_cal   (w_cal)
    );

    assign w_uw        = cdad_pkg::ucode(r_pc);
    assign w_off       = s_axis_tdata[23 +: OFFSET_BITS];
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_neg       = r_r[RW-1];

    // Year split into century and year of century: the reciprocal of 100 scaled by
    // 2^19 is exact for every 14-bit year.
    assign w_prod = 27'(r_y) * 27'd5243;
    assign w_q    = w_prod[26:19];
    assign w_hund = 14'(w_q) * 14'd100;
    assign w_rem  = r_y - w_hund;

    assign w_dim_cur  = $signed({{(RW-5){1'b0}}, w_cal.dim_cur});
    assign w_dim_prev = $signed({{(RW-5){1'b0}}, w_cal.dim_prev});
    assign w_diy_cur  = $signed({{(RW-9){1'b0}}, w_cal.diy_cur});
    assign w_diy_prev = $signed({{(RW-9){1'b0}}, w_cal.diy_prev});

    always_comb begin
        case (w_uw.cond)
            cdad_pkg::C_NEVER:     w_cond = 1'b0;
            cdad_pkg::C_BAD_YM:    w_cond = (r_y < cdad_pkg::YEAR_MIN) ||
                                            (r_y > cdad_pkg::YEAR_MAX) ||
                                            (r_m < cdad_pkg::MONTH_JAN) ||
                                            (r_m > cdad_pkg::MONTH_DEC);
            cdad_pkg::C_BAD_DAY:   w_cond = (r_in_d == 5'd0) || (r_in_d > w_cal.dim_cur);
            cdad_pkg::C_M_IS_1:    w_cond = (r_m == cdad_pkg::MONTH_JAN);
            cdad_pkg::C_R_NEG:     w_cond = w_neg;
            cdad_pkg::C_BACK_STOP: w_cond = !w_neg || (r_y == cdad_pkg::YEAR_MIN);
            cdad_pkg::C_R_NONNEG:  w_cond = !w_neg;
            cdad_pkg::C_FWD_STOP:  w_cond = (r_r < w_diy_cur) || (r_y == cdad_pkg::YEAR_MAX);
            cdad_pkg::C_R_LT_DIY:  w_cond = (r_r < w_diy_cur);
            cdad_pkg::C_R_LT_DIM:  w_cond = (r_r < w_dim_cur);
            default:               w_cond = 1'b0;
        endcase
    end

    always_comb begin
        n_pc        = r_pc;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_in_y      = r_in_y;
        n_in_m      = r_in_m;
        n_in_d      = r_in_d;
        n_y         = r_y;
        n_yc        = r_yc;
        n_yl        = r_yl;
        n_m         = r_m;
        n_r         = r_r;
        n_res_y     = r_res_y;
        n_res_m     = r_res_m;
        n_res_d     = r_res_d;
        n_res_st    = r_res_st;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (!r_busy) begin
            if (s_axis_tvalid) begin
                n_busy = 1'b1;
                n_pc   = cdad_pkg::PC_SPLIT;
                n_in_y = s_axis_tdata[13:0];
                n_in_m = s_axis_tdata[17:14];
                n_in_d = s_axis_tdata[22:18];
                n_y    = s_axis_tdata[13:0];
                n_m    = s_axis_tdata[17:14];
                // Offset counted from the first of the start month.
                n_r    = $signed({{(RW-OFFSET_BITS){w_off[OFFSET_BITS-1]}}, w_off}) +
                         $signed({{(RW-5){1'b0}}, s_axis_tdata[22:18]}) -
                         $signed(RW'(1));
            end
        end else if (w_cond) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = w_uw.next;
            case (w_uw.op)
                cdad_pkg::OP_NOP: begin
                end
                cdad_pkg::OP_SPLIT: begin
                    n_yc = w_q[6:0];
                    n_yl = w_rem[6:0];
                end
                cdad_pkg::OP_MDEC: begin
                    n_m = r_m - 4'd1;
                    n_r = r_r + w_dim_prev;
                end
                cdad_pkg::OP_YDEC_ADD: begin
                    n_y = r_y - 14'd1;
                    n_r = r_r + w_diy_prev;
                    if (r_yl == 7'd0) begin
                        n_yl = cdad_pkg::YL_LAST;
                        n_yc = r_yc - 7'd1;
                    end else begin
                        n_yl = r_yl - 7'd1;
                    end
                end
                cdad_pkg::OP_SUBY_YINC: begin
                    n_y = r_y + 14'd1;
                    n_r = r_r - w_diy_cur;
                    if (r_yl == cdad_pkg::YL_LAST) begin
                        n_yl = 7'd0;
                        n_yc = r_yc + 7'd1;
                    end else begin
                        n_yl = r_yl + 7'd1;
                    end
                end
                cdad_pkg::OP_MINC: begin
                    n_m = r_m + 4'd1;
                    n_r = r_r - w_dim_cur;
                end
                cdad_pkg::OP_FIN_OK, cdad_pkg::OP_FIN_RANGE, cdad_pkg::OP_FIN_INV: begin
                    if (w_slot_free) begin
                        n_busy      = 1'b0;
                        n_out_valid = 1'b1;
                        if (w_uw.op == cdad_pkg::OP_FIN_OK) begin
                            n_res_y  = r_y;
                            n_res_m  = r_m;
                            n_res_d  = r_r[4:0] + 5'd1;
                            n_res_st = cdad_pkg::ST_OK;
                        end else begin
                            n_res_y  = r_in_y;
                            n_res_m  = r_in_m;
                            n_res_d  = r_in_d;
                            n_res_st = (w_uw.op == cdad_pkg::OP_FIN_RANGE) ?
                                       cdad_pkg::ST_RANGE : cdad_pkg::ST_INVALID;
                        end
                    end else begin
                        n_pc = r_pc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= cdad_pkg::PC_SPLIT;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_in_y   <= n_in_y;
        r_in_m   <= n_in_m;
        r_in_d   <= n_in_d;
        r_y      <= n_y;
        r_yc     <= n_yc;
        r_yl     <= n_yl;
        r_m      <= n_m;
        r_r      <= n_r;
        r_res_y  <= n_res_y;
        r_res_m  <= n_res_m;
        r_res_d  <= n_res_d;
        r_res_st <= n_res_st;
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res_d, r_res_m, r_res_y};
    assign m_axis_tuser  = r_res_st;

endmodule

FILE: rtl/cdad_chk.sv
// Port-level assertions for the date shifter and the bind that attaches them.
`include "calendar_date_add_days_macros.svh"

module cdad_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Only one request is in progress at a time.
    `CDAD_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")

    `CDAD_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tuser == cdad_pkg::ST_OK) || (m_axis_tuser == cdad_pkg::ST_INVALID) || (m_axis_tuser == cdad_pkg::ST_RANGE), "unknown status code")

    // A date reported as good has a real month and a nonzero day.
    `CDAD_ASSERT(a_ok_date, m_axis_tvalid && (m_axis_tuser == cdad_pkg::ST_OK) |-> (m_axis_tdata[17:14] != 4'd0) && (m_axis_tdata[17:14] <= cdad_pkg::MONTH_DEC) && (m_axis_tdata[22:18] != 5'd0), "good result with bad month or day")

    `CDAD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind calendar_date_add_days cdad_chk u_cdad_chk (.*);

FILE: dv/calendar_date_add_days_tb.sv
// Testbench for the date shifter: directed and random date requests checked against a predictor.
module calendar_date_add_days_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OFFSET_W     = 20;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT  = 2_500_000;

    typedef struct packed {
        logic [13:0]                 year;
        logic [3:0]                  month;
        logic [4:0]                  day;
        logic signed [OFFSET_W-1:0]  offset;
    } t_date_request;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [1:0]  status;
    } t_shifted_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // start_year[13:0], start_month[17:14], start_day[22:18], day_offset[42:23], zero fill
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result_year[13:0], result_month[17:14], result_day[22:18], zero fill
    logic [23:0] m_axis_tdata;
    // status[1:0]
    logic [1:0]  m_axis_tuser;

    t_shifted_date pending_dates[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   holds_asked;
    int unsigned   holds_granted = 0;

    calendar_date_add_days #(
        .OFFSET_BITS(OFFSET_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Days elapsed since 0001-01-01 for a valid date.
    function automatic longint days_since_epoch(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        longint      n;
        int unsigned p;
        p = y - 1;
        n = longint'(p) * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned i = 1; i < m; i++) begin
            n += month_days(y, i);
        end
        return n + d - 1;
    endfunction

    function automatic t_shifted_date shift_date(input t_date_request rq);
        t_shifted_date r;
        longint        n;
        int unsigned   y;
        int unsigned   m;
        r.year   = rq.year;
        r.month  = rq.month;
        r.day    = rq.day;
        r.status = cdad_pkg::ST_OK;
        if (rq.year < cdad_pkg::YEAR_MIN || rq.year > cdad_pkg::YEAR_MAX
                || rq.month < cdad_pkg::MONTH_JAN
                || rq.month > cdad_pkg::MONTH_DEC || rq.day == 0
                || rq.day > month_days(rq.year, rq.month)) begin
            r.status = cdad_pkg::ST_INVALID;
        end else begin
            n = days_since_epoch(rq.year, rq.month, rq.day) + longint'(rq.offset);
            if (n < 0 || n > days_since_epoch(9999, 12, 31)) begin
                r.status = cdad_pkg::ST_RANGE;
            end else begin
                // Start at or below the true year and step up to it.
                y = int'(n / 366) + 1;
                while (days_since_epoch(y + 1, 1, 1) <= n) y++;
                m = 1;
                while (m < 12 && days_since_epoch(y, m + 1, 1) <= n) m++;
                r.year  = y[13:0];
                r.month = m[3:0];
                r.day   = 5'(n - days_since_epoch(y, m, 1) + 1);
            end
        end
        return r;
    endfunction

    function automatic t_date_request random_valid_date(input int unsigned ylo,
                                                        input int unsigned yhi);
        t_date_request rq;
        int unsigned   y;
        int unsigned   m;
        y = $urandom_range(ylo, yhi);
        m = $urandom_range(1, 12);
        rq.year   = y[13:0];
        rq.month  = m[3:0];
        rq.day    = 5'($urandom_range(1, month_days(y, m)));
        rq.offset = '0;
        return rq;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Offers one request and returns at the edge where it is taken; valid stays high
    // so that a following request can go out back to back.
    task automatic send_date_request(input logic [13:0] y, input logic [3:0] m,
                                     input logic [4:0] d, input int off,
                                     input bit allow_gap);
        t_date_request rq;
        int unsigned   gap;
        rq.year   = y;
        rq.month  = m;
        rq.day    = d;
        rq.offset = off[OFFSET_W-1:0];
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, rq.offset, rq.day, rq.month, rq.year};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_dates.push_back(shift_date(rq));
    endtask

    task automatic test_calendar_edges();
        send_date_request(14'd1,    4'd1,  5'd1,  0,       1);
        send_date_request(14'd9999, 4'd12, 5'd31, 0,       1);
        send_date_request(14'd1,    4'd1,  5'd1,  524287,  1);
        send_date_request(14'd9999, 4'd12, 5'd31, -524288, 1);
        send_date_request(14'd2000, 4'd2,  5'd28, 1,       1);
        send_date_request(14'd1900, 4'd2,  5'd28, 1,       1);
        send_date_request(14'd2024, 4'd2,  5'd29, -366,    1);
        send_date_request(14'd2004, 4'd12, 5'd31, 1,       1);
        send_date_request(14'd2005, 4'd1,  5'd1,  -1,      1);
        send_date_request(14'd2000, 4'd3,  5'd1,  -1,      1);
    endtask

    task automatic test_invalid_dates();
        send_date_request(14'd0,     4'd6,  5'd15, 10, 1);
        send_date_request(14'h3FFF,  4'd6,  5'd15, 10, 1);
        send_date_request(14'd10000, 4'd1,  5'd1,  -5, 1);
        send_date_request(14'd1999,  4'd0,  5'd10, 3,  1);
        send_date_request(14'd1999,  4'd15, 5'd31, 3,  1);
        send_date_request(14'd1999,  4'd13, 5'd1,  3,  1);
        send_date_request(14'd1999,  4'd5,  5'd0,  3,  1);
        send_date_request(14'd1999,  4'd4,  5'd31, 3,  1);
        send_date_request(14'd1900,  4'd2,  5'd29, 1,  1);
    endtask

    task automatic test_out_of_range();
        send_date_request(14'd1,    4'd1,  5'd1,  -1,      1);
        send_date_request(14'd9999, 4'd12, 5'd31, 1,       1);
        send_date_request(14'd1,    4'd1,  5'd1,  -524288, 1);
        send_date_request(14'd9999, 4'd12, 5'd31, 524287,  1);
    endtask

    // The sink stops taking results while short requests keep coming, so the block
    // fills up and has to hold off the sender.
    task automatic test_output_backpressure();
        t_date_request rq;
        holds_asked <= holds_asked + 1;
        for (int i = 0; i < 12; i++) begin
            rq = random_valid_date(1, 9999);
            send_date_request(rq.year, rq.month, rq.day, int'($urandom_range(0, 80)) - 40, 0);
        end
    endtask

    task automatic test_random_dates();
        t_date_request rq;
        int unsigned   roll;
        int            off;
        for (int i = 0; i < 255; i++) begin
            roll = $urandom_range(0, 99);
            rq   = random_valid_date(1, 9999);
            if (roll < 55) begin
                off = int'($urandom_range(0, 1600)) - 800;
            end else if (roll < 80) begin
                off = int'($urandom());
            end else if (roll < 88) begin
                // Near the ends of the calendar, so results run off it now and then.
                rq  = ($urandom_range(0, 1) == 1) ? random_valid_date(9997, 9999)
                                                  : random_valid_date(1, 3);
                off = int'($urandom_range(0, 2400)) - 1200;
            end else begin
                rq.year  = 14'($urandom());
                rq.month = 4'($urandom());
                rq.day   = 5'($urandom());
                off      = int'($urandom());
            end
            send_date_request(rq.year, rq.month, rq.day, off, (i % 60) >= 12);
        end
    endtask

    // Result sink ready: random stalls, free-running stretches, and requested hold-offs.
    always @(posedge i_clk) begin : sink_ready_ctrl
        int unsigned stall_left;
        int unsigned free_left;
        int unsigned hold_left;
        int unsigned roll;
        if (holds_granted != holds_asked) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (free_left > 0) begin
            free_left--;
            m_axis_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                free_left = $urandom_range(20, 120);
                m_axis_tready <= 1'b1;
            end else if (roll < 13) begin
                stall_left = $urandom_range(20, 100);
                m_axis_tready <= 1'b0;
            end else if (roll < 45) begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_shifted_date got;
        t_shifted_date want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.year   = m_axis_tdata[13:0];
            got.month  = m_axis_tdata[17:14];
            got.day    = m_axis_tdata[22:18];
            got.status = m_axis_tuser;
            if (pending_dates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result %0d-%0d-%0d status %0d",
                             got.year, got.month, got.day, got.status);
                end
            end else begin
                want = pending_dates.pop_front();
                if (got.year !== want.year || got.month !== want.month
                        || got.day !== want.day || got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                                 want.year, want.month, want.day, want.status,
                                 got.year, got.month, got.day, got.status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("calendar_date_add_days: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        holds_asked    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calendar_edges();
        test_invalid_dates();
        test_out_of_range();
        test_output_backpressure();
        test_random_dates();

        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("calendar_date_add_days: match");
        end else begin
            $display("calendar_date_add_days: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cdad_pkg.sv
rtl/cdad_cal.sv
rtl/calendar_date_add_days.sv
rtl/cdad_chk.sv
dv/calendar_date_add_days_tb.sv
